### hdl/scba_pkg.sv
package scba_pkg;

   // Fixed widths of the request and response fields.
   localparam int ACTION_W  = 1;
   localparam int SIZE_W    = 16;
   localparam int ALIGN_W   = 8;
   localparam int OFFSET_W  = 18;

   // Blocks are tracked per 16-byte granule; class zero holds 16-byte blocks.
   localparam int GRANULE_SHIFT = 4;
   localparam int MIN_BLOCK     = 16;
   localparam logic [ALIGN_W-1:0] MAX_ALIGN = 8'd16;

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DISPATCH,
      ST_BUMP_CMP,
      ST_POP,
      ST_DONE
   } state_type;

   // Operations of the shared add/subtract unit.
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage

### hdl/scba_alu.sv
// Shared add/subtract unit. The top bit of a subtraction is the borrow,
// so a clear top bit means operand a is at least operand b.
module scba_alu #(
   parameter int AW = 20
) (
   input  scba_pkg::alu_op_type op,
   input  logic [AW-1:0]        a,
   input  logic [AW-1:0]        b,
   output logic [AW:0]          y
);

   always_comb begin
      unique case (op)
         scba_pkg::ALU_ADD: y = {1'b0, a} + {1'b0, b};
         scba_pkg::ALU_SUB: y = {1'b0, a} - {1'b0, b};
         default:           y = {1'b0, a} - {1'b0, b};
      endcase
   end

endmodule

### hdl/scba_link_ram.sv
// Single-port-write, single-port-read memory holding the free-list links,
// one entry per granule, with a registered read.
module scba_link_ram #(
   parameter int DEPTH  = 16384,
   parameter int ADDR_W = 14,
   parameter int DATA_W = 15
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/size_class_block_allocator.sv
// Size-class block allocator over a pool of POOL_BYTES bytes with NUM_CLASSES
// power-of-two classes starting at 16 bytes. A request is taken when start is
// high and busy is low; busy then stays high until the single response has
// been shown. The response appears on rsp_granted and rsp_result_offset for
// exactly one cycle with rsp_valid high and cannot be held off. An allocate
// for class k runs a class search through the shared compare unit over
// classes 0 to k, a dispatch step, then either the pop, which takes the
// registered link read, or the arena bound check, and then the response,
// also when the arena turns out to be exhausted; frees and allocates
// refused for their alignment skip the pop or bound check, and a size above
// the largest class fails once all NUM_CLASSES classes have been searched.
// The next request may be taken in the cycle after the strobe. The link
// memory is not cleared, so no clearing pass is needed after reset.
module size_class_block_allocator #(
   parameter int POOL_BYTES  = 262144,
   parameter int NUM_CLASSES = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [scba_pkg::ACTION_W-1:0]       req_action,
   input  logic [scba_pkg::SIZE_W-1:0]         req_request_size,
   input  logic [scba_pkg::ALIGN_W-1:0]        req_alignment,
   input  logic [scba_pkg::OFFSET_W-1:0]       req_block_offset,
   output logic                                rsp_valid,
   output logic                                rsp_granted,
   output logic [scba_pkg::OFFSET_W-1:0]       rsp_result_offset
);

   localparam int NUM_GRANULES = POOL_BYTES / scba_pkg::MIN_BLOCK;
   localparam int IDX_W  = (NUM_GRANULES > 1) ? $clog2(NUM_GRANULES) : 1;
   localparam int LINK_W = IDX_W + 1;
   localparam int BUMP_W = $clog2(POOL_BYTES + 1);
   localparam int AW     = ((BUMP_W > 17) ? BUMP_W : 17) + 1;
   localparam int K_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int OIDX_W = scba_pkg::OFFSET_W - scba_pkg::GRANULE_SHIFT;

   // Sequencer and request registers.
   scba_pkg::state_type state_ff, state_in;
   logic [K_W-1:0]                   k_ff, k_in;
   logic [scba_pkg::ACTION_W-1:0]    action_ff, action_in;
   logic [scba_pkg::SIZE_W-1:0]      size_ff, size_in;
   logic [scba_pkg::ALIGN_W-1:0]     align_ff, align_in;
   logic [scba_pkg::OFFSET_W-1:0]    offset_ff, offset_in;

   // Allocator state.
   logic [LINK_W-1:0] heads_ff [NUM_CLASSES];
   logic [LINK_W-1:0] heads_in [NUM_CLASSES];
   logic [BUMP_W-1:0] bump_used_ff, bump_used_in;
   logic [AW-1:0]     sum_ff, sum_in;

   // Response registers.
   logic                          granted_ff, granted_in;
   logic [scba_pkg::OFFSET_W-1:0] result_ff, result_in;

   // Shared unit and link memory connections.
   scba_pkg::alu_op_type alu_op;
   logic [AW-1:0]        alu_a, alu_b;
   logic [AW:0]          alu_y;
   logic                 alu_ge;
   logic                 ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [LINK_W-1:0]    ram_wr_data, ram_rd_data;

   logic                 accept;
   logic                 last_class;
   logic [LINK_W-1:0]    head_sel;
   logic [AW-1:0]        blk_size;
   logic [OIDX_W-1:0]    off_idx;

   assign accept     = start && (state_ff == scba_pkg::ST_IDLE);
   assign last_class = (k_ff == K_W'(NUM_CLASSES - 1));
   assign head_sel   = heads_ff[k_ff];
   assign blk_size   = AW'(scba_pkg::MIN_BLOCK) << k_ff;
   assign off_idx    = offset_ff[scba_pkg::OFFSET_W-1:scba_pkg::GRANULE_SHIFT];
   assign alu_ge     = !alu_y[AW];

   scba_alu #(
      .AW (AW)
   ) u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   scba_link_ram #(
      .DEPTH  (NUM_GRANULES),
      .ADDR_W (IDX_W),
      .DATA_W (LINK_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scba_pkg::ST_IDLE: begin
            if (start) begin
               state_in = scba_pkg::ST_SCAN;
            end
         end
         scba_pkg::ST_SCAN: begin
            if (alu_ge) begin
               state_in = scba_pkg::ST_DISPATCH;
            end else if (last_class) begin
               state_in = scba_pkg::ST_DONE;
            end
         end
         scba_pkg::ST_DISPATCH: begin
            if (action_ff == scba_pkg::ACT_FREE || align_ff > scba_pkg::MAX_ALIGN) begin
               state_in = scba_pkg::ST_DONE;
            end else if (head_sel[LINK_W-1]) begin
               state_in = scba_pkg::ST_POP;
            end else begin
               state_in = scba_pkg::ST_BUMP_CMP;
            end
         end
         scba_pkg::ST_BUMP_CMP: state_in = scba_pkg::ST_DONE;
         scba_pkg::ST_POP:      state_in = scba_pkg::ST_DONE;
         scba_pkg::ST_DONE:     state_in = scba_pkg::ST_IDLE;
         default:               state_in = scba_pkg::ST_IDLE;
      endcase
   end

   // Control of the shared unit and the link memory.
   always_comb begin
      alu_op      = scba_pkg::ALU_SUB;
      alu_a       = blk_size;
      alu_b       = AW'(size_ff);
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_addr = IDX_W'(off_idx);
      ram_wr_data = head_sel;
      ram_rd_addr = head_sel[IDX_W-1:0];
      unique case (state_ff)
         scba_pkg::ST_SCAN: begin
            // Does block size of class k hold the requested size?
            alu_op = scba_pkg::ALU_SUB;
            alu_a  = blk_size;
            alu_b  = AW'(size_ff);
         end
         scba_pkg::ST_DISPATCH: begin
            if (action_ff == scba_pkg::ACT_FREE) begin
               // Granule index must lie inside the pool.
               alu_op    = scba_pkg::ALU_SUB;
               alu_a     = AW'(NUM_GRANULES - 1);
               alu_b     = AW'(off_idx);
               ram_wr_en = alu_ge;
            end else begin
               // Arena end after carving one block of this class.
               alu_op    = scba_pkg::ALU_ADD;
               alu_a     = AW'(bump_used_ff);
               alu_b     = blk_size;
               ram_rd_en = (align_ff <= scba_pkg::MAX_ALIGN) && head_sel[LINK_W-1];
            end
         end
         scba_pkg::ST_BUMP_CMP: begin
            alu_op = scba_pkg::ALU_SUB;
            alu_a  = AW'(POOL_BYTES);
            alu_b  = sum_ff;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      k_in         = k_ff;
      action_in    = action_ff;
      size_in      = size_ff;
      align_in     = align_ff;
      offset_in    = offset_ff;
      bump_used_in = bump_used_ff;
      sum_in       = sum_ff;
      granted_in   = granted_ff;
      result_in    = result_ff;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         heads_in[i] = heads_ff[i];
      end
      unique case (state_ff)
         scba_pkg::ST_IDLE: begin
            if (start) begin
               k_in       = '0;
               action_in  = req_action;
               size_in    = req_request_size;
               align_in   = req_alignment;
               offset_in  = req_block_offset;
               granted_in = 1'b0;
               result_in  = '0;
            end
         end
         scba_pkg::ST_SCAN: begin
            if (!alu_ge && !last_class) begin
               k_in = k_ff + K_W'(1);
            end
         end
         scba_pkg::ST_DISPATCH: begin
            if (action_ff == scba_pkg::ACT_FREE) begin
               if (alu_ge) begin
                  heads_in[k_ff] = {1'b1, IDX_W'(off_idx)};
                  granted_in     = 1'b1;
               end
            end else begin
               sum_in = alu_y[AW-1:0];
            end
         end
         scba_pkg::ST_BUMP_CMP: begin
            if (alu_ge) begin
               result_in    = scba_pkg::OFFSET_W'(bump_used_ff);
               bump_used_in = sum_ff[BUMP_W-1:0];
               granted_in   = 1'b1;
            end
         end
         scba_pkg::ST_POP: begin
            heads_in[k_ff] = ram_rd_data;
            result_in      = scba_pkg::OFFSET_W'(
               AW'(head_sel[IDX_W-1:0]) << scba_pkg::GRANULE_SHIFT);
            granted_in     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scba_pkg::ST_IDLE;
         bump_used_ff <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bump_used_ff <= bump_used_in;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i] <= heads_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      action_ff  <= action_in;
      size_ff    <= size_in;
      align_ff   <= align_in;
      offset_ff  <= offset_in;
      sum_ff     <= sum_in;
      granted_ff <= granted_in;
      result_ff  <= result_in;
   end

   assign busy              = (state_ff != scba_pkg::ST_IDLE);
   assign rsp_valid         = (state_ff == scba_pkg::ST_DONE);
   assign rsp_granted       = granted_ff;
   assign rsp_result_offset = result_ff;

   // A refused request never reports an offset.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_result_offset == '0)
      else $error("refused request carries a nonzero offset");

   // A pop only follows a dispatch that saw a non-empty list.
   a_pop_valid_head: assert property (@(posedge clock) disable iff (reset)
      state_ff == scba_pkg::ST_POP |->
         $past(state_ff) == scba_pkg::ST_DISPATCH && $past(head_sel[LINK_W-1]))
      else $error("pop issued on an empty free list");

   // The arena never grows past the pool.
   a_bump_bound: assert property (@(posedge clock) disable iff (reset)
      AW'(bump_used_ff) <= AW'(POOL_BYTES))
      else $error("bump arena exceeds the pool");

   // An accepted request keeps the block busy until its response strobe.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_valid)
      else $error("accepted request did not hold busy");

   // The response strobe lasts one cycle and frees the block.
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response strobe longer than one cycle");

endmodule
